// File: rtl/core/etli_pkg.sv
// Package for the Earth orientation table interpolator.
// Holds the widths, record and handshake types, command codes and field helpers.
// Used by every module of the block; depends on nothing.
package etli_pkg;

    // Table size and fixed point format.
    localparam int TABLE_DEPTH   = 1024;
    localparam int FRACTION_BITS = 24;
    localparam int ADDR_W        = $clog2(TABLE_DEPTH);
    localparam int CNT_W         = ADDR_W + 1;

    // Field widths.
    localparam int MJD_W  = 41;
    localparam int VAL_W  = 29;
    localparam int UT_W   = 26;
    localparam int NVALS  = 6;
    localparam int K_W    = $clog2(NVALS);
    localparam int K_UT   = 2;

    // Ratio, divider and multiplier widths.
    localparam int TINT_W    = 30;
    localparam int TMAG_W    = TINT_W + FRACTION_BITS + 1;
    localparam int DVD_W     = MJD_W + FRACTION_BITS;
    localparam int DCNT_W    = $clog2(DVD_W + 1);
    localparam int MD_W      = VAL_W + 1;
    localparam int MUL_LO_W  = (TMAG_W + 1) / 2;
    localparam int MUL_HI_W  = TMAG_W - MUL_LO_W;
    localparam int PROD_W    = TMAG_W + MD_W;
    localparam int SH_W      = PROD_W - FRACTION_BITS;
    localparam int M_W       = 41;
    localparam int SUM_W     = M_W + 1;
    localparam int MAC_PH    = 5;
    localparam int PH_W      = $clog2(MAC_PH);

    // Result status codes.
    localparam logic [1:0] ST_INTERP = 2'd0;
    localparam logic [1:0] ST_LAST   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_SPAN   = 2'd3;

    // Memory read address selection.
    localparam logic [1:0] RD_SRCH = 2'd0;
    localparam logic [1:0] RD_IDX0 = 2'd1;
    localparam logic [1:0] RD_IDX1 = 2'd2;
    localparam logic [1:0] RD_LAST = 2'd3;

    // One stored record; the date sits in the lowest bits as on the stream.
    typedef struct packed {
        logic signed [VAL_W-1:0] nutation_dy;
        logic signed [VAL_W-1:0] nutation_dx;
        logic signed [VAL_W-1:0] day_length_excess;
        logic signed [UT_W-1:0]  ut1_minus_utc;
        logic signed [VAL_W-1:0] pole_y;
        logic signed [VAL_W-1:0] pole_x;
        logic [MJD_W-1:0]        date_mjd;
    } t_rec;

    localparam int REC_W   = $bits(t_rec);
    localparam int TDATA_W = ((REC_W + 7) / 8) * 8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             wr;
        logic             cap_q;
        logic             srch_init;
        logic             srch_step;
        logic [1:0]       rd_sel;
        logic             lat0;
        logic             lat1;
        logic             setup;
        logic             div_init;
        logic             div_step;
        logic             tload;
        logic             mac_en;
        logic [PH_W-1:0]  mac_ph;
        logic [K_W-1:0]   mac_k;
        logic             out_load;
        logic [1:0]       out_sel;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic hit;
        logic srch_end;
        logic idx_last;
        logic span_zero;
        logic out_free;
    } t_stat;

    // Value k of a record, sign extended to the common width.
    function automatic logic signed [VAL_W-1:0] rec_val(input t_rec r,
                                                         input logic [K_W-1:0] k);
        logic signed [VAL_W-1:0] v;
        case (k)
            3'd0: v = r.pole_x;
            3'd1: v = r.pole_y;
            3'd2: v = {{(VAL_W-UT_W){r.ut1_minus_utc[UT_W-1]}}, r.ut1_minus_utc};
            3'd3: v = r.day_length_excess;
            3'd4: v = r.nutation_dx;
            3'd5: v = r.nutation_dy;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Saturate a sum to the range of field k.
    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SUM_W-1:0] v,
                                                         input logic [K_W-1:0] k);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        logic signed [VAL_W-1:0] res;
        if (k == K_W'(K_UT)) begin
            hi = {{(SUM_W-UT_W+1){1'b0}}, {(UT_W-1){1'b1}}};
        end else begin
            hi = {{(SUM_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
        end
        lo = ~hi;
        if (v > hi) begin
            res = hi[VAL_W-1:0];
        end else if (v < lo) begin
            res = lo[VAL_W-1:0];
        end else begin
            res = v[VAL_W-1:0];
        end
        return res;
    endfunction

endpackage

// File: rtl/core/etli_ctrl.sv
// Controller state machine of the Earth orientation table interpolator.
// Sequences append, search, record fetch, divide and multiply-add steps.
// Depends on etli_pkg.
module etli_ctrl
    import etli_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    input  logic  i_op,
    output logic  o_s_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SRCH  = 4'd1;
    localparam logic [3:0] S_RDL   = 4'd2;
    localparam logic [3:0] S_WL    = 4'd3;
    localparam logic [3:0] S_RD0   = 4'd4;
    localparam logic [3:0] S_RD1   = 4'd5;
    localparam logic [3:0] S_L1    = 4'd6;
    localparam logic [3:0] S_SETUP = 4'd7;
    localparam logic [3:0] S_CHK   = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_TLD   = 4'd10;
    localparam logic [3:0] S_MAC   = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    logic [3:0]        r_state, n_state;
    logic [1:0]        r_sel, n_sel;
    logic [DCNT_W-1:0] r_cnt, n_cnt;
    logic [PH_W-1:0]   r_ph, n_ph;
    logic [K_W-1:0]    r_k, n_k;
    logic              w_acc;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_acc      = i_s_tvalid && o_s_tready;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        n_cnt   = r_cnt;
        n_ph    = r_ph;
        n_k     = r_k;
        o_cmd   = '0;
        o_cmd.mac_ph = r_ph;
        o_cmd.mac_k  = r_k;
        o_cmd.out_sel = r_sel;
        case (r_state)
            S_IDLE: begin
                if (w_acc && !i_op) begin
                    o_cmd.wr = 1'b1;
                end else if (w_acc) begin
                    o_cmd.cap_q     = 1'b1;
                    o_cmd.srch_init = 1'b1;
                    n_state         = S_SRCH;
                end
            end
            S_SRCH: begin
                o_cmd.srch_step = 1'b1;
                o_cmd.rd_sel    = RD_SRCH;
                if (i_stat.empty) begin
                    n_sel   = ST_EMPTY;
                    n_state = S_OUT;
                end else if (i_stat.hit || i_stat.srch_end) begin
                    n_state = i_stat.idx_last ? S_RDL : S_RD0;
                end
            end
            S_RDL: begin
                o_cmd.rd_sel = RD_LAST;
                n_state      = S_WL;
            end
            S_WL: begin
                o_cmd.lat0 = 1'b1;
                n_sel      = ST_LAST;
                n_state    = S_OUT;
            end
            S_RD0: begin
                o_cmd.rd_sel = RD_IDX0;
                n_state      = S_RD1;
            end
            S_RD1: begin
                o_cmd.rd_sel = RD_IDX1;
                o_cmd.lat0   = 1'b1;
                n_state      = S_L1;
            end
            S_L1: begin
                o_cmd.lat1 = 1'b1;
                n_state    = S_SETUP;
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = S_CHK;
            end
            S_CHK: begin
                if (i_stat.span_zero) begin
                    n_sel   = ST_SPAN;
                    n_state = S_OUT;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_cnt          = '0;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(DVD_W - 1)) begin
                    n_state = S_TLD;
                end
            end
            S_TLD: begin
                o_cmd.tload = 1'b1;
                n_ph        = '0;
                n_k         = '0;
                n_state     = S_MAC;
            end
            S_MAC: begin
                o_cmd.mac_en = 1'b1;
                if (r_ph == PH_W'(MAC_PH - 1)) begin
                    n_ph = '0;
                    if (r_k == K_W'(NVALS - 1)) begin
                        n_sel   = ST_INTERP;
                        n_state = S_OUT;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end else begin
                    n_ph = r_ph + 1'b1;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= ST_INTERP;
            r_cnt   <= '0;
            r_ph    <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            r_cnt   <= n_cnt;
            r_ph    <= n_ph;
            r_k     <= n_k;
        end
    end

endmodule

// File: rtl/core/etli_dpath.sv
// Datapath of the Earth orientation table interpolator: record memory, search
// compare, radix-2 divider, split multiplier with saturation, output register.
// Depends on etli_pkg.
module etli_dpath
    import etli_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  t_rec               i_rec,
    input  logic               i_restart,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [TDATA_W-1:0] o_m_tdata,
    output logic [1:0]         o_m_tuser
);

    t_rec                    r_mem [TABLE_DEPTH];
    t_rec                    r_rd;
    t_rec                    r_rec0, r_rec1;
    logic [CNT_W-1:0]        r_count;
    logic [MJD_W-1:0]        r_q;
    logic [CNT_W-1:0]        r_addr;
    logic                    r_cmp_v;
    logic [ADDR_W-1:0]       r_cmp_i;
    logic [ADDR_W-1:0]       r_idx;
    logic                    r_neg_t;
    logic                    r_span_zero;
    logic [MJD_W-1:0]        r_us;
    logic [MJD_W-1:0]        r_rem;
    logic [DVD_W-1:0]        r_dvd;
    logic [TMAG_W-1:0]       r_tmag;
    logic signed [VAL_W-1:0] r_v0;
    logic                    r_neg;
    logic [MD_W-1:0]         r_md;
    logic [MUL_LO_W+MD_W-1:0] r_plo;
    logic [MUL_HI_W+MD_W-1:0] r_phi;
    logic [M_W-1:0]          r_m;
    logic signed [VAL_W-1:0] r_res [NVALS];
    logic                    r_ovalid;
    logic [1:0]              r_ostat;
    logic [MJD_W-1:0]        r_omjd;
    logic signed [VAL_W-1:0] r_oval [NVALS];

    logic [CNT_W-1:0]        w_base;
    logic                    w_store;
    logic [ADDR_W-1:0]       w_ra;
    logic                    w_issue;
    logic                    w_gt;
    logic [MJD_W:0]          w_dq, w_span;
    logic [MJD_W:0]          w_rem2;
    logic                    w_qbit;
    logic signed [VAL_W:0]   w_d;
    logic [PROD_W-1:0]       w_sum;
    logic [SH_W-1:0]         w_sh;
    logic signed [SUM_W-1:0] w_v0x, w_mx, w_res;

    // Append address and table capacity.
    assign w_base  = i_restart ? '0 : r_count;
    assign w_store = (w_base < CNT_W'(TABLE_DEPTH));

    // Memory read address.
    always_comb begin
        case (i_cmd.rd_sel)
            RD_SRCH: w_ra = r_addr[ADDR_W-1:0];
            RD_IDX0: w_ra = r_idx;
            RD_IDX1: w_ra = r_idx + 1'b1;
            RD_LAST: w_ra = ADDR_W'(r_count - 1'b1);
            default: w_ra = r_idx;
        endcase
    end

    // Record memory, one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && w_store) begin
            r_mem[w_base[ADDR_W-1:0]] <= i_rec;
        end
        r_rd <= r_mem[w_ra];
    end

    // Record count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.wr) begin
            r_count <= w_store ? w_base + 1'b1 : w_base;
        end
    end

    // Linear search: one read issued per cycle, compared in the cycle after.
    assign w_issue = (r_addr < r_count);
    assign w_gt    = r_cmp_v && (r_rd.date_mjd > r_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_v <= 1'b0;
            r_addr  <= '0;
            r_idx   <= '0;
        end else if (i_cmd.srch_init) begin
            r_cmp_v <= 1'b0;
            r_addr  <= '0;
            r_idx   <= '0;
        end else if (i_cmd.srch_step) begin
            r_cmp_v <= w_issue;
            if (w_issue) begin
                r_addr <= r_addr + 1'b1;
            end
            if (r_cmp_v && !w_gt) begin
                r_idx <= r_cmp_i;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.srch_step) begin
            r_cmp_i <= r_addr[ADDR_W-1:0];
        end
        if (i_cmd.cap_q) begin
            r_q <= i_rec.date_mjd;
        end
        if (i_cmd.lat0) begin
            r_rec0 <= r_rd;
        end
        if (i_cmd.lat1) begin
            r_rec1 <= r_rd;
        end
    end

    assign o_stat.empty     = (r_count == '0);
    assign o_stat.hit       = w_gt;
    assign o_stat.srch_end  = !w_issue && !r_cmp_v;
    assign o_stat.idx_last  = ({1'b0, r_idx} >= r_count - 1'b1);
    assign o_stat.span_zero = r_span_zero;
    assign o_stat.out_free  = !r_ovalid || i_m_tready;

    // Offset and span of the bracketing pair.
    assign w_dq   = {1'b0, r_q} - {1'b0, r_rec0.date_mjd};
    assign w_span = {1'b0, r_rec1.date_mjd} - {1'b0, r_rec0.date_mjd};

    // Restoring divider, one quotient bit per cycle, dividend scaled by the fraction.
    assign w_rem2 = {r_rem, r_dvd[DVD_W-1]};
    assign w_qbit = (w_rem2 >= {1'b0, r_us});

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_neg_t     <= w_dq[MJD_W] ^ w_span[MJD_W];
            r_span_zero <= (w_span == '0);
            r_us        <= w_span[MJD_W] ? MJD_W'(-w_span) : w_span[MJD_W-1:0];
            r_dvd       <= {(w_dq[MJD_W] ? MJD_W'(-w_dq) : w_dq[MJD_W-1:0]),
                            {FRACTION_BITS{1'b0}}};
        end
        if (i_cmd.div_init) begin
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_qbit ? MJD_W'(w_rem2 - {1'b0, r_us}) : w_rem2[MJD_W-1:0];
            r_dvd <= {r_dvd[DVD_W-2:0], w_qbit};
        end
        // Ratio clamped to the integer limit.
        if (i_cmd.tload) begin
            if (r_dvd[DVD_W-1:TMAG_W-1] != '0) begin
                r_tmag <= {1'b1, {(TMAG_W-1){1'b0}}};
            end else begin
                r_tmag <= r_dvd[TMAG_W-1:0];
            end
        end
    end

    // Multiply-add, five phases per value.
    assign w_d   = rec_val(r_rec1, i_cmd.mac_k) - rec_val(r_rec0, i_cmd.mac_k);
    assign w_sum = PROD_W'(r_plo) + (PROD_W'(r_phi) << MUL_LO_W);
    assign w_sh  = w_sum[PROD_W-1:FRACTION_BITS];
    assign w_v0x = SUM_W'(r_v0);
    assign w_mx  = {1'b0, r_m};
    assign w_res = r_neg ? w_v0x - w_mx : w_v0x + w_mx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mac_en) begin
            case (i_cmd.mac_ph)
                3'd0: begin
                    r_v0  <= rec_val(r_rec0, i_cmd.mac_k);
                    r_neg <= r_neg_t ^ w_d[VAL_W];
                    r_md  <= w_d[VAL_W] ? MD_W'(-w_d) : MD_W'(w_d);
                end
                3'd1: begin
                    r_plo <= r_tmag[MUL_LO_W-1:0] * r_md;
                end
                3'd2: begin
                    r_phi <= r_tmag[TMAG_W-1:MUL_LO_W] * r_md;
                end
                3'd3: begin
                    if (w_sh > SH_W'({1'b1, {(M_W-1){1'b0}}})) begin
                        r_m <= {1'b1, {(M_W-1){1'b0}}};
                    end else begin
                        r_m <= w_sh[M_W-1:0];
                    end
                end
                3'd4: begin
                    r_res[i_cmd.mac_k] <= sat_val(w_res, i_cmd.mac_k);
                end
                default: begin
                    r_m <= r_m;
                end
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_ostat <= i_cmd.out_sel;
            r_omjd  <= (i_cmd.out_sel == ST_LAST) ? r_rec0.date_mjd : r_q;
            for (int k = 0; k < NVALS; k++) begin
                case (i_cmd.out_sel)
                    ST_INTERP: r_oval[k] <= r_res[k];
                    ST_LAST:   r_oval[k] <= rec_val(r_rec0, K_W'(k));
                    default:   r_oval[k] <= '0;
                endcase
            end
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_ostat;
    assign o_m_tdata  = TDATA_W'({r_oval[5], r_oval[4], r_oval[3],
                                  r_oval[2][UT_W-1:0], r_oval[1], r_oval[0], r_omjd});

endmodule

// File: rtl/core/eop_table_linear_interpolator.sv
// Earth orientation table interpolator, top level. Depends on etli_pkg, etli_ctrl, etli_dpath.
// An append request leaves the input ready for the next request. A query registers its result
// after the linear search, which reads the record memory once per cycle, the record fetch,
// a one-bit divider and six multiply-adds.
// One query is in work at a time; a new request is taken once the result is registered.
// Synchronous active-low reset empties the table and drops any pending result.
module eop_table_linear_interpolator
    import etli_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    // date_mjd, pole_x, pole_y, ut1_minus_utc, day_length_excess,
    // nutation_dx, nutation_dy, zero pad
    input  logic [TDATA_W-1:0] i_s_tdata,
    // operation, restart
    input  logic [1:0]         i_s_tuser,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    // out_mjd, out_pole_x, out_pole_y, out_ut1_minus_utc,
    // out_day_length_excess, out_nutation_dx, out_nutation_dy, zero pad
    output logic [TDATA_W-1:0] o_m_tdata,
    // status
    output logic [1:0]         o_m_tuser
);

    t_cmd  w_cmd;
    t_stat w_stat;
    t_rec  w_rec;

    assign w_rec = t_rec'(i_s_tdata[REC_W-1:0]);

    // Controller.
    etli_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_op       (i_s_tuser[0]),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Datapath.
    etli_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_rec      (w_rec),
        .i_restart  (i_s_tuser[1]),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

// File: rtl/core/etli_chk.sv
// Port checker for the Earth orientation table interpolator, bound to the top level.
// Depends on etli_pkg and eop_table_linear_interpolator.
module etli_chk
    import etli_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_s_tvalid,
    input logic               o_s_tready,
    input logic [TDATA_W-1:0] i_s_tdata,
    input logic [1:0]         i_s_tuser,
    input logic               o_m_tvalid,
    input logic               i_m_tready,
    input logic [TDATA_W-1:0] o_m_tdata,
    input logic [1:0]         o_m_tuser
);

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // Reset drops any result.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // An append request never produces a result.
    a_app: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && !i_s_tuser[0] && !o_m_tvalid |=> !o_m_tvalid)
        else $error("result after append");

    // A query request blocks the input while it is worked on.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser[0] |=> !o_s_tready)
        else $error("input accepted during query");

    // Error results carry zero values.
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == ST_EMPTY || o_m_tuser == ST_SPAN)
        |-> o_m_tdata[TDATA_W-1:MJD_W] == '0)
        else $error("error result with nonzero values");

endmodule

bind eop_table_linear_interpolator etli_chk u_etli_chk (.*);
